// ----- rtl/core/bgrhsl_pkg.sv -----
package bgrhsl_pkg;

  // Channel and result widths.
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SUM_W  = CHAN_W + 1;

  // Hue numerator term d reaches 7 * 255, so it needs 11 bits.
  localparam int unsigned D_W = 11;

  // Long division: quotient bits, bits resolved per stage and stage count.
  localparam int unsigned QUO_W      = 9;
  localparam int unsigned STEP_BITS  = 3;
  localparam int unsigned DIV_STAGES = QUO_W / STEP_BITS;

  // Remainder holds 85 * 1785 = 151725, divisor holds 2 * 255 = 510.
  localparam int unsigned REM_W  = 18;
  localparam int unsigned DIVR_W = 9;

  // Arithmetic constants of the conversion.
  localparam logic [REM_W-1:0] HUE_NUM      = REM_W'(85);
  localparam logic [SUM_W-1:0] FULL_SUM     = SUM_W'(510);
  localparam logic [D_W-1:0]   HUE_OFS_RED  = D_W'(6);
  localparam logic [D_W-1:0]   HUE_OFS_GRN  = D_W'(2);
  localparam logic [D_W-1:0]   HUE_OFS_BLU  = D_W'(4);
  localparam int unsigned      SAT_SHIFT    = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] lightness;
  } hsl_t;

  // State of one pixel inside the division pipeline.
  typedef struct packed {
    logic              grey;
    logic [CHAN_W-1:0] lightness;
    logic [REM_W-1:0]  hue_rem;
    logic [DIVR_W-1:0] hue_div;
    logic [QUO_W-1:0]  hue_q;
    logic [REM_W-1:0]  sat_rem;
    logic [DIVR_W-1:0] sat_div;
    logic [QUO_W-1:0]  sat_q;
  } work_t;

endpackage

// ----- rtl/core/bgrhsl_prep.sv -----
module bgrhsl_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  bgrhsl_pkg::pixel_t  pixel,
  output logic                work_valid,
  input  logic                work_ready,
  output bgrhsl_pkg::work_t   work
);
  import bgrhsl_pkg::*;

  typedef struct packed {
    logic              grey;
    logic [CHAN_W-1:0] lightness;
    logic [CHAN_W-1:0] range;
    logic [D_W-1:0]    d;
    logic [CHAN_W-1:0] den;
  } prep_t;

  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] range;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  half;
  logic [SUM_W-1:0]  den_w;
  logic [D_W-1:0]    range_w;
  logic [D_W-1:0]    d_calc;
  prep_t             prep_next;
  prep_t             s1;
  logic              s1_valid;
  logic              s1_load;
  logic              s2_load;
  work_t             work_next;

  // Stage one: extremes, range, sum, hue term and saturation divisor.
  always_comb begin
    mx = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
    range   = mx - mn;
    sum     = {1'b0, mx} + {1'b0, mn};
    range_w = D_W'(range);
    // The true value always lies in 0..1785, so wrapping arithmetic is exact.
    priority if (pixel.red == mx) begin
      d_calc = D_W'(pixel.green) + range_w * HUE_OFS_RED - D_W'(pixel.blue);
    end else if (pixel.green == mx) begin
      d_calc = D_W'(pixel.blue) + range_w * HUE_OFS_GRN - D_W'(pixel.red);
    end else begin
      d_calc = D_W'(pixel.red) + range_w * HUE_OFS_BLU - D_W'(pixel.green);
    end
    half  = FULL_SUM - sum;
    den_w = (half < sum) ? half : sum;
    if (den_w == '0) den_w = SUM_W'(1);
    prep_next.grey      = (range == '0);
    prep_next.lightness = sum[SUM_W-1:1];
    prep_next.range     = range;
    prep_next.d         = d_calc;
    prep_next.den       = den_w[CHAN_W-1:0];
  end

  // Stage two: scaled numerators and divisors.
  always_comb begin
    work_next.grey      = s1.grey;
    work_next.lightness = s1.lightness;
    work_next.hue_rem   = REM_W'(s1.d) * HUE_NUM;
    work_next.hue_div   = {s1.range, 1'b0};
    work_next.hue_q     = '0;
    work_next.sat_rem   = (REM_W'(s1.range) << SAT_SHIFT) - REM_W'(s1.range);
    work_next.sat_div   = DIVR_W'(s1.den);
    work_next.sat_q     = '0;
  end

  assign s2_load     = !work_valid || work_ready;
  assign s1_load     = !s1_valid || s2_load;
  assign pixel_ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      work_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= pixel_valid;
      if (s2_load) work_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && pixel_valid) s1 <= prep_next;
    if (s2_load && s1_valid) work <= work_next;
  end

endmodule

// ----- rtl/core/bgrhsl_div_stage.sv -----
module bgrhsl_div_stage #(
  parameter int unsigned TopBit = bgrhsl_pkg::QUO_W - 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  bgrhsl_pkg::work_t  up_work,
  output logic               dn_valid,
  input  logic               dn_ready,
  output bgrhsl_pkg::work_t  dn_work
);
  import bgrhsl_pkg::*;

  work_t work_next;
  logic  load;

  // Restoring division, several quotient bits per stage for both quotients.
  always_comb begin
    logic [REM_W-1:0] hsh;
    logic [REM_W-1:0] ssh;
    work_next = up_work;
    for (int i = 0; i < STEP_BITS; i++) begin
      hsh = REM_W'(work_next.hue_div) << (TopBit - i);
      ssh = REM_W'(work_next.sat_div) << (TopBit - i);
      if (work_next.hue_rem >= hsh) begin
        work_next.hue_rem = work_next.hue_rem - hsh;
        work_next.hue_q   = work_next.hue_q | (QUO_W'(1) << (TopBit - i));
      end
      if (work_next.sat_rem >= ssh) begin
        work_next.sat_rem = work_next.sat_rem - ssh;
        work_next.sat_q   = work_next.sat_q | (QUO_W'(1) << (TopBit - i));
      end
    end
  end

  assign load     = !dn_valid || dn_ready;
  assign up_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) dn_work <= work_next;
  end

endmodule

// ----- rtl/core/bgr_to_hsl_pixel_top.sv -----
// Pixel color converter from blue, green, red to hue, saturation, lightness.
//
// Input channel pixel_valid / pixel_ready / pixel carries one pixel of three
// 8-bit channels per beat. Output channel hsl_valid / hsl_ready / hsl carries
// one result per beat, in the order the pixels were taken.
//
// Throughput is one pixel per clock, sustained, as long as hsl_ready stays
// high. The pipeline has five register stages: extremes and hue term,
// numerator scaling, then three long division stages that each settle
// three quotient bits of the hue and saturation quotients side by side.
//
// Every stage holds its own valid bit and loads when it is empty or when the
// stage below takes its beat, so a stalled receiver only backs up the
// pipeline as far as needed; bubbles are squeezed out and no beat is lost or
// repeated. pixel_ready drops only when all five stages hold beats.
//
// Synchronous reset on rst empties the pipeline: all valid bits clear and
// hsl_valid is low in the cycle after reset.
module bgr_to_hsl_pixel_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  bgrhsl_pkg::pixel_t  pixel,
  output logic                hsl_valid,
  input  logic                hsl_ready,
  output bgrhsl_pkg::hsl_t    hsl
);
  import bgrhsl_pkg::*;

  // Stage k hands its beat to stage k + 1 over these links.
  logic  stage_valid [DIV_STAGES+1];
  logic  stage_ready [DIV_STAGES+1];
  work_t stage_work  [DIV_STAGES+1];
  work_t last;

  // Front end: extremes, range, sum, then the scaled numerators.
  bgrhsl_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .work_valid  (stage_valid[0]),
    .work_ready  (stage_ready[0]),
    .work        (stage_work[0])
  );

  // Division stages, most significant quotient bits first.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    bgrhsl_div_stage #(
      .TopBit (QUO_W - 1 - k * STEP_BITS)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[k]),
      .up_ready (stage_ready[k]),
      .up_work  (stage_work[k]),
      .dn_valid (stage_valid[k+1]),
      .dn_ready (stage_ready[k+1]),
      .dn_work  (stage_work[k+1])
    );
  end

  assign last                    = stage_work[DIV_STAGES];
  assign hsl_valid               = stage_valid[DIV_STAGES];
  assign stage_ready[DIV_STAGES] = hsl_ready;

  // A grey pixel has a zero hue divisor, so its quotients mean nothing and
  // both hue and saturation are forced to zero. Hue wraps modulo 256.
  always_comb begin
    hsl.hue        = last.grey ? '0 : last.hue_q[CHAN_W-1:0];
    hsl.saturation = last.grey ? '0 : last.sat_q[CHAN_W-1:0];
    hsl.lightness  = last.lightness;
  end

`ifndef SYNTH
  // A finished non-grey division leaves both remainders below their divisors.
  assert property (@(posedge clk) disable iff (rst)
    (hsl_valid && !last.grey) |->
      (last.hue_rem < REM_W'(last.hue_div)) && (last.sat_rem < REM_W'(last.sat_div)))
    else $error("division remainder not below divisor at output");

  // The saturation divisor is clamped and never reaches zero.
  assert property (@(posedge clk) disable iff (rst)
    hsl_valid |-> (last.sat_div != '0))
    else $error("zero saturation divisor at output");

  // The input side only stalls when the output holds a beat that is not taken.
  assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> (hsl_valid && !hsl_ready))
    else $error("input stalled while output is free");
`endif

endmodule
